@@ hw/rtl/rip_relative_lea_target_scanner_unit_macros.svh @@
// assertion macros for the scanner unit
// the module that uses them must provide aclk and aresetn
`ifndef RIP_RELATIVE_LEA_TARGET_SCANNER_UNIT_MACROS_SVH
`define RIP_RELATIVE_LEA_TARGET_SCANNER_UNIT_MACROS_SVH

// checked only while out of reset
`define RRLTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define RRLTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/rrlts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrlts_pkg
// Types, constants and decode helpers of the RIP-relative LEA target scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrlts_pkg;

    localparam int OFFSET_BITS    = 32;
    localparam int ADDR_BITS      = 64;
    localparam int WIN_BYTES      = 6;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SECTION_BASE  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WANTED_TARGET = 1'd1;

    localparam logic [7:0] REX_HI_MASK  = 8'hF0;
    localparam logic [7:0] REX_HI_CODE  = 8'h40;
    localparam logic [7:0] REX_W_BIT    = 8'h08;
    localparam logic [7:0] LEA_OPC_BYTE = 8'h8D;
    localparam logic [7:0] MODRM_MASK   = 8'hC7;
    localparam logic [7:0] MODRM_RIP    = 8'h05;
    localparam logic [OFFSET_BITS-1:0] FIRST_END_OFS = OFFSET_BITS'(6);
    localparam logic [ADDR_BITS-1:0]   START_BACK    = ADDR_BITS'(6);
    localparam logic [ADDR_BITS-1:0]   END_AHEAD     = ADDR_BITS'(1);

    typedef logic [7:0] byte_t;
    typedef byte_t [WIN_BYTES-1:0] window_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] instr_addr;
    } out_word_t;

    typedef struct packed {
        logic                   match_done;
        logic [OFFSET_BITS-1:0] byte_offset;
    } scan_status_t;

    function automatic logic is_rex_w(input byte_t b);
        return ((b & REX_HI_MASK) == REX_HI_CODE) && ((b & REX_W_BIT) != 8'h00);
    endfunction

    function automatic logic is_rip_modrm(input byte_t b);
        return (b & MODRM_MASK) == MODRM_RIP;
    endfunction

endpackage

@@ hw/rtl/rrlts_byte_cell.sv @@
// ----------------------------------------------------------------------------
// rrlts_byte_cell
// One byte stage of the sliding window; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrlts_byte_cell (
    input  logic           aclk,
    input  logic           shift_en,
    input  rrlts_pkg::byte_t byte_in,
    output rrlts_pkg::byte_t byte_out
);

    rrlts_pkg::byte_t byte_reg;
    rrlts_pkg::byte_t byte_next;

    always_comb begin
        byte_next = shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

@@ hw/rtl/rrlts_match_unit.sv @@
// ----------------------------------------------------------------------------
// rrlts_match_unit
// Decodes the window ending at the current byte and checks the LEA target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrlts_match_unit (
    input  rrlts_pkg::window_t                   window,
    input  rrlts_pkg::byte_t                     cur_byte,
    input  rrlts_pkg::scan_status_t              status,
    input  logic [rrlts_pkg::ADDR_BITS-1:0]      section_base,
    input  logic [rrlts_pkg::ADDR_BITS-1:0]      wanted_target,
    output logic                                 hit,
    output logic [rrlts_pkg::ADDR_BITS-1:0]      start_addr
);

    logic                               saturated;
    logic                               armed;
    logic                               shape_ok;
    logic [31:0]                        disp;
    logic [rrlts_pkg::ADDR_BITS-1:0]    ofs_ext;
    logic [rrlts_pkg::ADDR_BITS-1:0]    disp_ext;
    logic [rrlts_pkg::ADDR_BITS-1:0]    target;

    always_comb begin
        saturated = &status.byte_offset;
        armed     = !status.match_done && !saturated &&
                    (status.byte_offset >= rrlts_pkg::FIRST_END_OFS);
        // oldest byte sits in the far cell
        shape_ok  = rrlts_pkg::is_rex_w(window[5]) &&
                    (window[4] == rrlts_pkg::LEA_OPC_BYTE) &&
                    rrlts_pkg::is_rip_modrm(window[3]);
        disp      = {cur_byte, window[0], window[1], window[2]};
        ofs_ext   = rrlts_pkg::ADDR_BITS'(status.byte_offset);
        disp_ext  = {{(rrlts_pkg::ADDR_BITS-32){disp[31]}}, disp};
        start_addr = section_base + ofs_ext - rrlts_pkg::START_BACK;
        // start + 7 + disp, folded onto the current offset
        target    = section_base + ofs_ext + disp_ext + rrlts_pkg::END_AHEAD;
        hit       = armed && shape_ok && (target == wanted_target);
    end

endmodule

@@ hw/rtl/rip_relative_lea_target_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// rip_relative_lea_target_scanner_unit
// Streams code bytes through a six-cell window and reports the first LEA whose
// RIP-relative target equals the configured address, or not-found at the end.
// ----------------------------------------------------------------------------
// a result word goes into the output register, or the skid word while that waits
// throughput: one byte per cycle while s_ready is high; the window check and
//   target add: a single combinational stage from byte cells to output register
// a two-entry output buffer keeps s_ready high while one result waits
// reset (aresetn low, synchronous) clears offset, match flag, buffer and
//   both configuration registers; window bytes are not reset
`timescale 1ns / 1ps

`include "rip_relative_lea_target_scanner_unit_macros.svh"

module rip_relative_lea_target_scanner_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  rrlts_pkg::in_word_t                      s_word,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output rrlts_pkg::out_word_t                     m_word,
    input  logic                                     cfg_we,
    input  logic [rrlts_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [rrlts_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

    logic [rrlts_pkg::ADDR_BITS-1:0]   base_reg;
    logic [rrlts_pkg::ADDR_BITS-1:0]   target_reg;
    logic [rrlts_pkg::OFFSET_BITS-1:0] offset_reg;
    logic [rrlts_pkg::OFFSET_BITS-1:0] offset_next;
    logic                              match_done_reg;
    logic                              match_done_next;

    logic                      out_valid_reg;
    rrlts_pkg::out_word_t      out_word_reg;
    logic                      skid_valid_reg;
    rrlts_pkg::out_word_t      skid_word_reg;

    rrlts_pkg::window_t        window;
    rrlts_pkg::scan_status_t   status;
    logic                      accept;
    logic                      hit;
    logic [rrlts_pkg::ADDR_BITS-1:0] start_addr;
    logic                      push;
    logic                      pop;
    rrlts_pkg::out_word_t      new_word;

    // byte cell chain, cell 0 takes the incoming byte
    for (genvar i = 0; i < rrlts_pkg::WIN_BYTES; i++) begin : g_cell
        rrlts_byte_cell u_cell (
            .aclk     (aclk),
            .shift_en (accept),
            .byte_in  ((i == 0) ? s_word.code_byte : window[(i == 0) ? 0 : i-1]),
            .byte_out (window[i])
        );
    end

    assign status.match_done  = match_done_reg;
    assign status.byte_offset = offset_reg;

    rrlts_match_unit u_match (
        .window        (window),
        .cur_byte      (s_word.code_byte),
        .status        (status),
        .section_base  (base_reg),
        .wanted_target (target_reg),
        .hit           (hit),
        .start_addr    (start_addr)
    );

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;
    assign pop     = out_valid_reg && m_ready;

    always_comb begin
        new_word.found      = hit;
        new_word.instr_addr = hit ? start_addr : '0;
        push = accept && (hit || (s_word.last_byte && !match_done_reg));

        offset_next     = offset_reg;
        match_done_next = match_done_reg;
        if (accept) begin
            if (!(&offset_reg)) begin
                offset_next = offset_reg + 1'b1;
            end
            if (hit) begin
                match_done_next = 1'b1;
            end
            if (s_word.last_byte) begin
                offset_next     = '0;
                match_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg     <= '0;
            match_done_reg <= 1'b0;
            base_reg       <= '0;
            target_reg     <= '0;
        end else begin
            offset_reg     <= offset_next;
            match_done_reg <= match_done_next;
            if (cfg_we) begin
                case (cfg_index)
                    rrlts_pkg::CFG_SECTION_BASE:  base_reg   <= cfg_wdata;
                    rrlts_pkg::CFG_WANTED_TARGET: target_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // output register plus one skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_word_reg   <= skid_word_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= push;
            out_word_reg  <= new_word;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
            skid_word_reg  <= new_word;
        end
    end

    `RRLTS_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid word without output word")
    `RRLTS_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !out_valid_reg && !skid_valid_reg, "buffer not empty after reset")
    `RRLTS_ASSERT(a_section_end_clears, accept && s_word.last_byte |=> offset_reg == '0 && !match_done_reg, "scan state kept past section end")
    `RRLTS_ASSERT(a_not_found_zero_addr, out_valid_reg && !out_word_reg.found |-> out_word_reg.instr_addr == '0, "not-found word with address")

endmodule

@@ dv/tb_rip_relative_lea_target_scanner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rip_relative_lea_target_scanner_unit
// Streams code sections through the scanner and checks every result word
// against a cycle-free model of the window match and target add, or the
// short table's word. Hand-written sections come first, then random
// sections with planted LEAs aimed at the target, near misses and broken
// encodings, over several base/target settings. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_rip_relative_lea_target_scanner_unit;
    import rrlts_pkg::*;

    localparam int RANDOM_WORDS  = 1800;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 500;
    localparam int HOLD_AFTER    = 40;
    localparam int DIR_ROWS      = 25;

    typedef enum {XP_MODEL, XP_NONE, XP_WORD} row_check_t;

    typedef struct {
        logic [7:0]           code;
        logic                 last;
        row_check_t           check;
        logic                 found;
        logic [ADDR_BITS-1:0] addr;
    } dir_row_t;

    // base and target are both zero here, so a displacement of -7 at offset 0 hits
    dir_row_t dir_rows [DIR_ROWS] = '{
        // short section
        '{8'h48, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h8D, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h05, 1'b1, XP_WORD,  1'b0, 64'd0},
        // hit at offset 0, then the last byte stays silent
        '{8'h48, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h8D, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h05, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hF9, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b0, XP_WORD,  1'b1, 64'd0},
        '{8'h00, 1'b1, XP_NONE,  1'b0, 64'd0},
        // hit on the last byte
        '{8'h4C, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h8D, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h3D, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hF9, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b1, XP_WORD,  1'b1, 64'd0},
        // rex without w
        '{8'h47, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h8D, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'h05, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hF9, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b0, XP_MODEL, 1'b0, 64'd0},
        '{8'hFF, 1'b1, XP_WORD,  1'b0, 64'd0}
    };

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    in_word_t                  s_word = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    out_word_t                 m_word;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_SECTION_BASE;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    always #2 aclk = ~aclk;

    rip_relative_lea_target_scanner_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // scanner model state
    logic [47:0]            win_bytes = '0;
    logic [OFFSET_BITS-1:0] scan_ofs = '0;
    logic                   scan_done = 1'b0;
    logic [ADDR_BITS-1:0]   scan_base = '0;
    logic [ADDR_BITS-1:0]   scan_target = '0;

    out_word_t expected_scans[$];
    in_word_t  sect_q[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;

    function automatic logic scan_lea_byte(input in_word_t w, output out_word_t r);
        logic [7:0]           rex_b, opc_b, modrm_b;
        logic [31:0]          disp;
        logic                 sat;
        logic                 hit;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] tgt;
        sat = (scan_ofs == '1);
        hit = 1'b0;
        start = '0;
        r = '0;
        rex_b = win_bytes[47:40];
        opc_b = win_bytes[39:32];
        modrm_b = win_bytes[31:24];
        if (!scan_done && !sat && scan_ofs >= OFFSET_BITS'(6)) begin
            if ((rex_b & REX_HI_MASK) == REX_HI_CODE && (rex_b & REX_W_BIT) != 8'h00 &&
                opc_b == LEA_OPC_BYTE && (modrm_b & MODRM_MASK) == MODRM_RIP) begin
                // little-endian displacement, top byte is the one arriving now
                disp = {w.code_byte, win_bytes[7:0], win_bytes[15:8], win_bytes[23:16]};
                start = scan_base + ADDR_BITS'(scan_ofs) - 64'd6;
                tgt = start + 64'd7 + {{32{disp[31]}}, disp};
                hit = (tgt == scan_target);
            end
        end
        win_bytes = {win_bytes[39:0], w.code_byte};
        if (!sat)
            scan_ofs = scan_ofs + 1'b1;
        if (hit) begin
            r.found = 1'b1;
            r.instr_addr = start;
            scan_done = 1'b1;
        end
        if (w.last_byte) begin
            if (!hit && scan_done)
                hit = 1'b1;
            else if (!hit) begin
                r = '0;
                scan_done = 1'b0;
                win_bytes = '0;
                scan_ofs = '0;
                return 1'b1;
            end else if (r.found == 1'b0) begin
                // section already matched earlier: silent end
                scan_done = 1'b0;
                win_bytes = '0;
                scan_ofs = '0;
                return 1'b0;
            end
            scan_done = 1'b0;
            win_bytes = '0;
            scan_ofs = '0;
        end
        return r.found;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic offer_word(input in_word_t w);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic set_scan_config(input logic [63:0] base, input logic [63:0] target);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SECTION_BASE;
        cfg_wdata <= base;
        @(posedge aclk);
        scan_base = base;
        cfg_index <= CFG_WANTED_TARGET;
        cfg_wdata <= target;
        @(posedge aclk);
        scan_target = target;
        cfg_we <= 1'b0;
    endtask

    // stop offering, let every result come back, then let the pipe settle
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic fill_section();
        logic [7:0]  bytes[$];
        logic [63:0] need;
        logic [31:0] disp;
        logic [7:0]  rex, opc, modrm;
        in_word_t    w;
        int          len, pick, p, kind;
        pick = $urandom_range(0, 19);
        len = (pick < 14) ? $urandom_range(1, 24) :
              (pick < 19) ? $urandom_range(25, 80) : $urandom_range(81, 300);
        repeat (len) bytes.insert(bytes.size(), 8'($urandom));
        if (len >= 7) begin
            repeat ($urandom_range(0, 3)) begin
                p = $urandom_range(0, len - 7);
                kind = $urandom_range(0, 10);
                rex = 8'h48 | 8'($urandom_range(0, 7));
                opc = LEA_OPC_BYTE;
                modrm = {2'b00, 3'($urandom_range(0, 7)), 3'b101};
                need = scan_target - scan_base - 64'(p) - 64'd7;
                if (need[63:31] == '0 || need[63:31] == '1)
                    disp = need[31:0];
                else
                    disp = $urandom;
                case (kind)
                    6: disp = disp + 32'd1;
                    7: disp = disp - 32'd1;
                    8: rex = {4'h4 ^ 4'($urandom_range(1, 15)), 4'($urandom)};
                    9: begin
                        if ($urandom_range(0, 1) == 0)
                            rex = {4'h4, 1'b0, 3'($urandom)};
                        else
                            modrm = {2'($urandom_range(1, 3)), 3'($urandom), 3'b101};
                    end
                    10: opc = LEA_OPC_BYTE ^ 8'($urandom_range(1, 255));
                    default: ;
                endcase
                bytes[p]   = rex;
                bytes[p+1] = opc;
                bytes[p+2] = modrm;
                bytes[p+3] = disp[7:0];
                bytes[p+4] = disp[15:8];
                bytes[p+5] = disp[23:16];
                bytes[p+6] = disp[31:24];
            end
        end
        sect_q.delete();
        foreach (bytes[i]) begin
            w.code_byte = bytes[i];
            w.last_byte = (i == len - 1);
            sect_q.insert(sect_q.size(), w);
        end
    endtask

    // result side: random stall pattern plus one long hold to back the block up
    int  rx_mode = 0;
    int  rx_mode_left = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(10, 150);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_scans.size() == 0) begin
                report_mismatch($sformatf("unexpected word found=%0b addr=%h",
                                          m_word.found, m_word.instr_addr));
            end else begin
                want = expected_scans.pop_front();
                if (m_word.found !== want.found)
                    report_mismatch($sformatf("found %0b, want %0b",
                                              m_word.found, want.found));
                if (m_word.instr_addr !== want.instr_addr)
                    report_mismatch($sformatf("instr_addr %h, want %h",
                                              m_word.instr_addr, want.instr_addr));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("stalled for %0d cycles, %0d words still due",
                 idle_cycles, expected_scans.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [63:0] ph_base [PHASES];
        logic [63:0] ph_target [PHASES];
        logic [31:0] r;
        in_word_t    w;
        out_word_t   res;
        logic        got;
        int          phase_words;

        ph_base[0] = '1;                          ph_target[0] = 64'h100;
        ph_base[1] = '0;                          ph_target[1] = '1;
        r = $urandom;
        ph_base[2] = {$urandom, $urandom};
        ph_target[2] = ph_base[2] + {{33{r[30]}}, r[30:0]};
        // small offsets give displacements right at the positive limit
        ph_base[3] = 64'h8000_0000_0000_0000;     ph_target[3] = ph_base[3] + 64'h8000_0006;
        // only offset 0 reaches the most negative displacement
        ph_base[4] = {$urandom, $urandom};
        ph_target[4] = ph_base[4] + 64'd7 - 64'h8000_0000;
        ph_base[5] = {$urandom, $urandom};        ph_target[5] = {$urandom, $urandom};
        ph_base[6] = 64'h7FFF_FFFF_FFFF_FFF8;     ph_target[6] = ph_base[6] + 64'h40;
        r = $urandom;
        ph_base[7] = {$urandom, $urandom};
        ph_target[7] = ph_base[7] + {{57{r[6]}}, r[6:0]};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        set_scan_config('0, '0);

        for (int i = 0; i < DIR_ROWS; i++) begin
            w.code_byte = dir_rows[i].code;
            w.last_byte = dir_rows[i].last;
            offer_word(w);
            got = scan_lea_byte(w, res);
            case (dir_rows[i].check)
                XP_MODEL: if (got) expected_scans.insert(expected_scans.size(), res);
                XP_WORD: begin
                    res.found = dir_rows[i].found;
                    res.instr_addr = dir_rows[i].addr;
                    expected_scans.insert(expected_scans.size(), res);
                end
                default: ;
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_idle();
            set_scan_config(ph_base[ph], ph_target[ph]);
            phase_words = 0;
            while (phase_words < RANDOM_WORDS / PHASES) begin
                fill_section();
                foreach (sect_q[k]) begin
                    offer_word(sect_q[k]);
                    if (scan_lea_byte(sect_q[k], res))
                        expected_scans.insert(expected_scans.size(), res);
                    phase_words++;
                end
            end
        end

        settle_idle();
        if (expected_scans.size() != 0)
            report_mismatch($sformatf("%0d words never came", expected_scans.size()));
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
